FILE: sv/rlcr_pkg.sv
// rlcr_pkg: shared types and constants for the rectangle list clip region
// no dependencies; imported by the front, back and top level modules
`default_nettype none

package rlcr_pkg;

  // mode field and read index widths are fixed by the item format
  localparam int MODE_W = 3;
  localparam int IDX_W  = 6;

  // operation codes, in the order of the mode field
  typedef enum logic [MODE_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_ASSIGN    = 3'd1,
    OP_INCLUDE   = 3'd2,
    OP_EXCLUDE   = 3'd3,
    OP_INTERSECT = 3'd4,
    OP_OVERLAP   = 3'd5,
    OP_POINT     = 3'd6,
    OP_READ      = 3'd7
  } op_t;

endpackage

`default_nettype wire

FILE: sv/rlcr_ram.sv
// rlcr_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rlcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/rlcr_front.sv
// rlcr_front: accepts input transactions, decodes the operation and queues them
// depends on rlcr_pkg
`default_nettype none

module rlcr_front import rlcr_pkg::*; #(
  parameter int CW = 16,
  localparam int EW = MODE_W + 6 * CW + IDX_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [CW-1:0]     rect_left,
  input  wire logic [CW-1:0]     rect_top,
  input  wire logic [CW-1:0]     rect_right,
  input  wire logic [CW-1:0]     rect_bottom,
  input  wire logic [CW-1:0]     point_x,
  input  wire logic [CW-1:0]     point_y,
  input  wire logic [IDX_W-1:0]  read_index,
  output logic                   q_valid,
  output logic [EW-1:0]          q_data,
  input  wire logic              q_pop
);

  typedef struct packed {
    op_t              op;
    logic [CW-1:0]    l;
    logic [CW-1:0]    t;
    logic [CW-1:0]    r;
    logic [CW-1:0]    b;
    logic [CW-1:0]    px;
    logic [CW-1:0]    py;
    logic [IDX_W-1:0] idx;
  } q_entry_t;

  q_entry_t   ent [2];
  q_entry_t   in_ent;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;

  // classify: mode becomes an operation code, unused coordinates are zeroed, read_index always passes
  always_comb begin
    in_ent     = '0;
    in_ent.op  = op_t'(mode);
    in_ent.idx = read_index;
    case (op_t'(mode))
      OP_POINT: begin
        in_ent.px = point_x;
        in_ent.py = point_y;
      end
      OP_CLEAR, OP_READ: begin
      end
      default: begin
        in_ent.l = rect_left;
        in_ent.t = rect_top;
        in_ent.r = rect_right;
        in_ent.b = rect_bottom;
      end
    endcase
  end

  assign item_stall = (cnt == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (cnt != 2'd0);
  assign q_data     = EW'(ent[rp]);

  // two entry queue towards the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        ent[wp] <= in_ent;
        wp      <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

FILE: sv/rlcr_back.sv
// rlcr_back: sequencer that carries out queued operations on the rectangle stores
// depends on rlcr_pkg and rlcr_ram
`default_nettype none

module rlcr_back import rlcr_pkg::*; #(
  parameter int MAX_RECTS = 64,
  parameter int CW = 16,
  localparam int EW = MODE_W + 6 * CW + IDX_W,
  localparam int CNT_W = $clog2(MAX_RECTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire logic [EW-1:0] q_data,
  output logic               q_pop,
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic               hit,
  output logic [CNT_W-1:0]   rect_count,
  output logic               overflow,
  output logic               read_valid,
  output logic [CW-1:0]      out_left,
  output logic [CW-1:0]      out_top,
  output logic [CW-1:0]      out_right,
  output logic [CW-1:0]      out_bottom
);

  localparam int AW    = $clog2(MAX_RECTS);
  localparam int BW    = 4 * CW;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int IW    = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECTS);
  localparam logic MEM_REGION  = 1'b0;
  localparam logic MEM_SCRATCH = 1'b1;

  typedef struct packed {
    op_t              op;
    logic [CW-1:0]    l;
    logic [CW-1:0]    t;
    logic [CW-1:0]    r;
    logic [CW-1:0]    b;
    logic [CW-1:0]    px;
    logic [CW-1:0]    py;
    logic [IDX_W-1:0] idx;
  } q_entry_t;

  typedef struct packed {
    logic signed [CW-1:0] l;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] b;
  } box_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INC_NEXT, S_INC_CAP, S_CUT_RD, S_CUT_EV, S_CUT_PC,
    S_APP_RD, S_APP_EV, S_IS_RD, S_IS_EV, S_Q_RD, S_Q_EV,
    S_RD_RD, S_RD_EV, S_DONE
  } state_t;

  function automatic logic overlaps(box_t a, box_t c);
    return !(c.r <= a.l || a.r <= c.l || c.b <= a.t || a.b <= c.t);
  endfunction

  state_t               state;
  q_entry_t             e;
  box_t                 qbox;
  op_t                  op_q;
  box_t                 opbox;
  box_t                 cbox;
  box_t                 abox;
  logic signed [CW-1:0] px_q;
  logic signed [CW-1:0] py_q;
  logic [IW-1:0]        idx_q;
  logic                 cur;
  logic                 sb;
  logic [CNT_W-1:0]     count;
  logic                 ovf;
  logic [CNT_W-1:0]     i;
  logic [CNT_W-1:0]     j;
  logic [CNT_W-1:0]     m;
  logic [CNT_W-1:0]     sn;
  logic [CNT_W-1:0]     cut_len;
  logic [1:0]           cut_src;
  logic [1:0]           cut_dst;
  logic [1:0]           stage;
  logic                 r_hit;
  logic                 r_rv;
  box_t                 r_box;

  // memory port controls
  logic          we;
  logic [1:0]    wsel;
  logic [AW-1:0] waddr;
  box_t          wdata;
  logic [AW-1:0] raddr;
  logic [1:0]    rsel;
  logic [1:0]    rsel_q;
  logic [BW-1:0] ram_rdata [4];
  box_t          rd;

  // derived per-state values
  logic pen;
  box_t pbox;
  box_t clip;
  logic clip_ok;
  logic q_hit;
  logic room;

  assign e          = q_entry_t'(q_data);
  assign qbox.l     = e.l;
  assign qbox.t     = e.t;
  assign qbox.r     = e.r;
  assign qbox.b     = e.b;
  assign rd         = box_t'(ram_rdata[rsel_q]);
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign room       = (m < MAX_CNT);

  // four stores: two region banks and two scratch banks, swapped after a cut
  for (genvar g = 0; g < 4; g++) begin : g_ram
    rlcr_ram #(.WIDTH(BW), .DEPTH(MAX_RECTS)) u_ram (
      .clk   (clk),
      .we    (we && (wsel == 2'(g))),
      .waddr (waddr),
      .wdata (BW'(wdata)),
      .raddr (raddr),
      .rdata (ram_rdata[g])
    );
  end

  // piece of the stored rectangle left over above, below, left or right of the cutter
  always_comb begin
    pbox = abox;
    case (stage)
      2'd0: begin
        pen    = cbox.t > abox.t;
        pbox.b = cbox.t;
      end
      2'd1: begin
        pen    = cbox.b < abox.b;
        pbox.t = cbox.b;
      end
      2'd2: begin
        pen    = cbox.l > abox.l;
        pbox.r = cbox.l;
      end
      default: begin
        pen    = cbox.r < abox.r;
        pbox.l = cbox.r;
      end
    endcase
  end

  // intersection clip and query tests on the rectangle just read
  always_comb begin
    clip   = rd;
    if (opbox.l > rd.l) clip.l = opbox.l;
    if (opbox.t > rd.t) clip.t = opbox.t;
    if (opbox.r < rd.r) clip.r = opbox.r;
    if (opbox.b < rd.b) clip.b = opbox.b;
    clip_ok = (clip.l <= clip.r) && (clip.t <= clip.b);
    if (op_q == OP_POINT) begin
      q_hit = (rd.l <= px_q) && (px_q < rd.r) && (rd.t <= py_q) && (py_q < rd.b);
    end else begin
      q_hit = overlaps(rd, opbox);
    end
  end

  // memory port steering
  always_comb begin
    we    = 1'b0;
    wsel  = 2'd0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    rsel  = 2'd0;
    case (state)
      S_IDLE: begin
        if (q_valid && e.op == OP_ASSIGN) begin
          we   = 1'b1;
          wsel = {MEM_REGION, cur};
          wdata = qbox;
        end else if (q_valid && e.op == OP_INCLUDE) begin
          we   = 1'b1;
          wsel = {MEM_SCRATCH, sb};
          wdata = qbox;
        end
      end
      S_INC_NEXT: begin
        raddr = j[AW-1:0];
        rsel  = {MEM_REGION, cur};
      end
      S_CUT_RD: begin
        raddr = i[AW-1:0];
        rsel  = cut_src;
      end
      S_CUT_EV: begin
        we    = !overlaps(rd, cbox) && room;
        wsel  = cut_dst;
        waddr = m[AW-1:0];
        wdata = rd;
      end
      S_CUT_PC: begin
        we    = pen && room;
        wsel  = cut_dst;
        waddr = m[AW-1:0];
        wdata = pbox;
      end
      S_APP_RD: begin
        raddr = i[AW-1:0];
        rsel  = {MEM_SCRATCH, sb};
      end
      S_APP_EV: begin
        we    = (count < MAX_CNT);
        wsel  = {MEM_REGION, cur};
        waddr = count[AW-1:0];
        wdata = rd;
      end
      S_IS_RD, S_Q_RD: begin
        raddr = i[AW-1:0];
        rsel  = {MEM_REGION, cur};
      end
      S_IS_EV: begin
        we    = clip_ok;
        wsel  = {MEM_REGION, cur};
        waddr = m[AW-1:0];
        wdata = clip;
      end
      S_RD_RD: begin
        raddr = idx_q[AW-1:0];
        rsel  = {MEM_REGION, cur};
      end
      default: begin
      end
    endcase
  end

  // sequencer state, list counters and result register
  always_ff @(posedge clk) begin
    rsel_q <= rsel;
    if (rst) begin
      state     <= S_IDLE;
      cur       <= 1'b0;
      sb        <= 1'b0;
      count     <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op_q  <= e.op;
            opbox <= qbox;
            cbox  <= qbox;
            px_q  <= e.px;
            py_q  <= e.py;
            idx_q <= IW'(e.idx);
            r_hit <= 1'b0;
            r_rv  <= 1'b0;
            r_box <= '0;
            i     <= '0;
            j     <= '0;
            m     <= '0;
            case (e.op)
              OP_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
                state <= S_DONE;
              end
              OP_ASSIGN: begin
                count <= CNT_W'(1);
                ovf   <= 1'b0;
                state <= S_DONE;
              end
              OP_INCLUDE: begin
                sn    <= CNT_W'(1);
                state <= S_INC_NEXT;
              end
              OP_EXCLUDE: begin
                cut_src <= {MEM_REGION, cur};
                cut_dst <= {MEM_REGION, ~cur};
                cut_len <= count;
                state   <= S_CUT_RD;
              end
              OP_INTERSECT: state <= S_IS_RD;
              OP_OVERLAP, OP_POINT: state <= S_Q_RD;
              default: begin
                if (CMP_W'(e.idx) < CMP_W'(count)) begin
                  state <= S_RD_RD;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_INC_NEXT: begin
          if (j < count && sn != '0) begin
            state <= S_INC_CAP;
          end else begin
            i     <= '0;
            state <= S_APP_RD;
          end
        end
        S_INC_CAP: begin
          cbox    <= rd;
          cut_src <= {MEM_SCRATCH, sb};
          cut_dst <= {MEM_SCRATCH, ~sb};
          cut_len <= sn;
          i       <= '0;
          m       <= '0;
          state   <= S_CUT_RD;
        end
        S_CUT_RD: begin
          if (i < cut_len) begin
            state <= S_CUT_EV;
          end else if (op_q == OP_EXCLUDE) begin
            cur   <= ~cur;
            count <= m;
            state <= S_DONE;
          end else begin
            sb    <= ~sb;
            sn    <= m;
            j     <= j + CNT_W'(1);
            state <= S_INC_NEXT;
          end
        end
        S_CUT_EV: begin
          if (!overlaps(rd, cbox)) begin
            if (room) m <= m + CNT_W'(1);
            else ovf <= 1'b1;
            i     <= i + CNT_W'(1);
            state <= S_CUT_RD;
          end else begin
            abox  <= rd;
            stage <= 2'd0;
            state <= S_CUT_PC;
          end
        end
        S_CUT_PC: begin
          if (pen) begin
            if (room) m <= m + CNT_W'(1);
            else ovf <= 1'b1;
            if (stage == 2'd0) abox.t <= cbox.t;
            if (stage == 2'd1) abox.b <= cbox.b;
          end
          stage <= stage + 2'd1;
          if (stage == 2'd3) begin
            i     <= i + CNT_W'(1);
            state <= S_CUT_RD;
          end
        end
        S_APP_RD: begin
          state <= (i < sn) ? S_APP_EV : S_DONE;
        end
        S_APP_EV: begin
          if (count < MAX_CNT) count <= count + CNT_W'(1);
          else ovf <= 1'b1;
          i     <= i + CNT_W'(1);
          state <= S_APP_RD;
        end
        S_IS_RD: begin
          if (i < count) begin
            state <= S_IS_EV;
          end else begin
            count <= m;
            state <= S_DONE;
          end
        end
        S_IS_EV: begin
          if (clip_ok) m <= m + CNT_W'(1);
          i     <= i + CNT_W'(1);
          state <= S_IS_RD;
        end
        S_Q_RD: begin
          state <= (i < count) ? S_Q_EV : S_DONE;
        end
        S_Q_EV: begin
          if (q_hit) begin
            r_hit <= 1'b1;
            state <= S_DONE;
          end else begin
            i     <= i + CNT_W'(1);
            state <= S_Q_RD;
          end
        end
        S_RD_RD: state <= S_RD_EV;
        S_RD_EV: begin
          r_box <= rd;
          r_rv  <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid  <= 1'b1;
            hit        <= r_hit;
            rect_count <= count;
            overflow   <= ovf;
            read_valid <= r_rv;
            out_left   <= r_box.l;
            out_top    <= r_box.t;
            out_right  <= r_box.r;
            out_bottom <= r_box.b;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/rect_list_clip_region.sv
// channel | valid      | stall      | payload
// item    | item_valid | item_stall | mode, rect_*, point_x, point_y, read_index
// result  | res_valid  | res_stall  | hit, rect_count, overflow, read_valid, out_*
//
// queries and intersect read and test the stored rectangles in turn; exclude keeps
// each untouched rectangle and splits each one it overlaps into its left over pieces
// include runs one cut of the scratch pieces per stored rectangle, then appends
// the pieces to the region list
// reset is synchronous; the stores need no clearing, count and overflow start at zero
// a result held by res_stall stops the back end; the two entry queue then stalls input
//
// rect_list_clip_region: top level of the rectangle list clip region
// depends on rlcr_pkg, rlcr_front, rlcr_back, rlcr_ram
`default_nettype none

module rect_list_clip_region import rlcr_pkg::*; #(
  parameter int MAX_RECTS = 64,
  parameter int COORD_BITS = 16,
  localparam int CNT_W = $clog2(MAX_RECTS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [COORD_BITS-1:0] rect_left,
  input  wire logic [COORD_BITS-1:0] rect_top,
  input  wire logic [COORD_BITS-1:0] rect_right,
  input  wire logic [COORD_BITS-1:0] rect_bottom,
  input  wire logic [COORD_BITS-1:0] point_x,
  input  wire logic [COORD_BITS-1:0] point_y,
  input  wire logic [IDX_W-1:0]      read_index,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output logic                       hit,
  output logic [CNT_W-1:0]           rect_count,
  output logic                       overflow,
  output logic                       read_valid,
  output logic [COORD_BITS-1:0]      out_left,
  output logic [COORD_BITS-1:0]      out_top,
  output logic [COORD_BITS-1:0]      out_right,
  output logic [COORD_BITS-1:0]      out_bottom
);

  localparam int EW = MODE_W + 6 * COORD_BITS + IDX_W;

  logic          q_valid;
  logic [EW-1:0] q_data;
  logic          q_pop;

  // front end: transaction intake and queue
  rlcr_front #(.CW(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .rect_left  (rect_left),
    .rect_top   (rect_top),
    .rect_right (rect_right),
    .rect_bottom(rect_bottom),
    .point_x    (point_x),
    .point_y    (point_y),
    .read_index (read_index),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  // back end: operation sequencer and stores
  rlcr_back #(.MAX_RECTS(MAX_RECTS), .CW(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .hit        (hit),
    .rect_count (rect_count),
    .overflow   (overflow),
    .read_valid (read_valid),
    .out_left   (out_left),
    .out_top    (out_top),
    .out_right  (out_right),
    .out_bottom (out_bottom)
  );

`ifndef NO_ASSERTIONS
  // count never goes beyond the store capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> rect_count <= CNT_W'(MAX_RECTS))
    else $error("rect_count beyond capacity");

  // a read back never reports a hit
  a_read_no_hit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && read_valid) |-> !hit)
    else $error("read result with hit set");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
